@@ design/tsgt_pkg.sv @@
// ----------------------------------------------------------------------------
// tsgt_pkg
// shared types, sizes and sequence-space helpers for the gap tracker
// ----------------------------------------------------------------------------
`default_nettype none

package tsgt_pkg;

    localparam int MAX_PENDING = 8;
    localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CNT_W = $clog2(MAX_PENDING + 1);

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_FIRST   = 3'd1;
    localparam logic [2:0] EV_ADVANCE = 3'd2;
    localparam logic [2:0] EV_RETRANS = 3'd3;
    localparam logic [2:0] EV_STORED  = 3'd4;
    localparam logic [2:0] EV_DROPPED = 3'd5;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
    } range_t;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] idx;
    } row_ctl_t;

    function automatic logic is_neg(input logic [31:0] d);
        return d[31];
    endfunction

    function automatic logic is_le0(input logic [31:0] d);
        return (d == 32'd0) || d[31];
    endfunction

    function automatic logic is_gt0(input logic [31:0] d);
        return !((d == 32'd0) || d[31]);
    endfunction

endpackage

`default_nettype wire

@@ design/tsgt_cell.sv @@
// ----------------------------------------------------------------------------
// tsgt_cell
// one pending-range slot: takes its neighbour's range or a loaded range
// ----------------------------------------------------------------------------
`default_nettype none

module tsgt_cell (
    input  wire logic            aclk,
    input  wire logic            shift,
    input  wire logic            load,
    input  wire tsgt_pkg::range_t shift_in,
    input  wire tsgt_pkg::range_t load_data,
    output tsgt_pkg::range_t      data
);

    tsgt_pkg::range_t data_reg;

    always_ff @(posedge aclk) begin
        // a load wins: it writes the tail slot after the row has moved
        if (load) begin
            data_reg <= load_data;
        end else if (shift) begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ design/tsgt_row.sv @@
// ----------------------------------------------------------------------------
// tsgt_row
// ordered row of range cells for one direction, read at the head
// ----------------------------------------------------------------------------
`default_nettype none

module tsgt_row (
    input  wire logic               aclk,
    input  wire tsgt_pkg::row_ctl_t ctl,
    input  wire tsgt_pkg::range_t   load_data,
    output tsgt_pkg::range_t        head
);

    tsgt_pkg::range_t cell_q [tsgt_pkg::MAX_PENDING];

    for (genvar i = 0; i < tsgt_pkg::MAX_PENDING; i++) begin : g_cell
        tsgt_pkg::range_t nb;
        if (i == tsgt_pkg::MAX_PENDING - 1) begin : g_last
            assign nb = cell_q[i];
        end else begin : g_mid
            assign nb = cell_q[i+1];
        end
        tsgt_cell u_cell (
            .aclk      (aclk),
            .shift     (ctl.shift),
            .load      (ctl.load && (ctl.idx == tsgt_pkg::IDX_W'(i))),
            .shift_in  (nb),
            .load_data (load_data),
            .data      (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

`default_nettype wire

@@ design/tcp_sequence_gap_tracker.sv @@
// ----------------------------------------------------------------------------
// tcp_sequence_gap_tracker
// per-direction expected sequence and pending out-of-order ranges of one flow
// ----------------------------------------------------------------------------
// the result follows the input beat through S_EVAL and S_DONE for no sequence
// space, a first segment or a retransmission; a gap adds an S_MERGE pass over
// the held ranges, an advance adds S_WALK passes, repeated while a fill moves
// the expected number; beats are taken one at a time, not before the last
// result is presented, which waits while an earlier result is not taken; reset:
// aresetn clears counters, marks, expected numbers and fill counts
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_sequence_gap_tracker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,  // seq_num[31:0], payload_len[47:32]
    input  wire logic [4:0]    s_tuser,  // direction, syn, ack, fin, rst
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // next_expected[31:0], pending_count[35:32], dir_packets[67:36],
    // dir_payload_bytes[115:68], total_packets[147:116],
    // total_payload_bytes[195:148], retransmit_total[227:196],
    // gap_total[259:228], handshake_done[260], fin_seen[262:261], reset_seen[263]
    output logic [263:0]       m_tdata,
    output logic [2:0]         m_tuser   // event_res
);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WALK, S_MERGE, S_DONE} state_t;

    localparam int CW = tsgt_pkg::CNT_W;

    state_t state_reg;

    logic        dir_reg;
    logic [31:0] seq_reg;
    logic [15:0] plen_reg;
    logic        syn_reg, ack_reg, fin_reg, rst_reg;

    logic [31:0] exp_reg [2];
    logic        started_reg [2];
    logic [CW-1:0] held_reg [2];
    logic [31:0] pkt_reg [2];
    logic [47:0] byte_reg [2];
    logic [31:0] retx_reg, gap_reg;
    logic [2:0]  hs_reg [2];
    logic [1:0]  fin_marks_reg;
    logic        rst_mark_reg;

    logic [2:0]    ev_reg;
    logic [CW-1:0] pass_reg;
    logic          matched_reg;
    logic [31:0]   cur_s_reg, cur_e_reg;

    logic         m_tvalid_reg;
    logic [263:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;

    tsgt_pkg::row_ctl_t ctl [2];
    tsgt_pkg::row_ctl_t ctl_c;
    tsgt_pkg::range_t   load_c;
    tsgt_pkg::range_t   head [2];
    tsgt_pkg::range_t   hd;

    for (genvar d = 0; d < 2; d++) begin : g_row
        assign ctl[d] = (dir_reg == 1'(d)) ? ctl_c : '0;
        tsgt_row u_row (
            .aclk      (aclk),
            .ctl       (ctl[d]),
            .load_data (load_c),
            .head      (head[d])
        );
    end

    assign hd = head[dir_reg];

    // segment end and length
    logic [16:0] slen;
    logic [31:0] send;
    logic [31:0] ds, de;
    logic [31:0] hds, hde;
    logic [31:0] ov_a, ov_b;
    logic        keep_c;
    logic [CW-1:0] held_cur;

    assign slen     = {1'b0, plen_reg} + {16'd0, syn_reg} + {16'd0, fin_reg};
    assign send     = seq_reg + {15'd0, slen};
    assign ds       = seq_reg - exp_reg[dir_reg];
    assign de       = send - exp_reg[dir_reg];
    assign hds      = hd.start - exp_reg[dir_reg];
    assign hde      = hd.stop - exp_reg[dir_reg];
    assign ov_a     = hd.start - cur_e_reg;
    assign ov_b     = hd.stop - cur_s_reg;
    assign held_cur = held_reg[dir_reg];

    always_comb begin
        ctl_c  = '0;
        load_c = hd;
        keep_c = 1'b1;
        if (state_reg == S_WALK && pass_reg != '0) begin
            keep_c = matched_reg ||
                     !(tsgt_pkg::is_le0(hde) ||
                       (tsgt_pkg::is_le0(hds) && tsgt_pkg::is_gt0(hde)));
            ctl_c.shift = 1'b1;
            ctl_c.load  = keep_c;
            ctl_c.idx   = tsgt_pkg::IDX_W'(held_cur - CW'(1));
        end else if (state_reg == S_MERGE && pass_reg != '0) begin
            keep_c = !(tsgt_pkg::is_le0(ov_a) && !tsgt_pkg::is_neg(ov_b));
            ctl_c.shift = 1'b1;
            ctl_c.load  = keep_c;
            ctl_c.idx   = tsgt_pkg::IDX_W'(held_cur - CW'(1));
        end else if (state_reg == S_MERGE && 32'(held_cur) < tsgt_pkg::MAX_PENDING) begin
            ctl_c.load  = 1'b1;
            ctl_c.idx   = tsgt_pkg::IDX_W'(held_cur);
            load_c      = '{start: cur_s_reg, stop: cur_e_reg};
        end
    end

    // result fields
    logic [32:0] tot_pkt;
    logic [48:0] tot_byte;
    logic [3:0]  held_wide;
    logic        hs_done;

    assign tot_pkt   = {1'b0, pkt_reg[0]} + {1'b0, pkt_reg[1]};
    assign tot_byte  = {1'b0, byte_reg[0]} + {1'b0, byte_reg[1]};
    assign held_wide = 4'(held_cur);
    assign hs_done   = (hs_reg[0][0] && hs_reg[1][1] && hs_reg[0][2]) ||
                       (hs_reg[1][0] && hs_reg[0][1] && hs_reg[1][2]);

    logic [48:0] byte_sum;
    assign byte_sum = {1'b0, byte_reg[dir_reg]} + {33'd0, plen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            for (int d = 0; d < 2; d++) begin
                exp_reg[d]     <= '0;
                started_reg[d] <= 1'b0;
                held_reg[d]    <= '0;
                pkt_reg[d]     <= '0;
                byte_reg[d]    <= '0;
                hs_reg[d]      <= '0;
            end
            retx_reg      <= '0;
            gap_reg       <= '0;
            fin_marks_reg <= '0;
            rst_mark_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        seq_reg   <= s_tdata[31:0];
                        plen_reg  <= s_tdata[47:32];
                        dir_reg   <= s_tuser[0];
                        syn_reg   <= s_tuser[1];
                        ack_reg   <= s_tuser[2];
                        fin_reg   <= s_tuser[3];
                        rst_reg   <= s_tuser[4];
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (pkt_reg[dir_reg] != '1) begin
                        pkt_reg[dir_reg] <= pkt_reg[dir_reg] + 32'd1;
                    end
                    byte_reg[dir_reg] <= byte_sum[48] ? '1 : byte_sum[47:0];
                    if (syn_reg && !ack_reg) hs_reg[dir_reg][0] <= 1'b1;
                    if (syn_reg && ack_reg) hs_reg[dir_reg][1] <= 1'b1;
                    if (ack_reg && !syn_reg && hs_reg[dir_reg][0] && hs_reg[!dir_reg][1]) begin
                        hs_reg[dir_reg][2] <= 1'b1;
                    end
                    if (fin_reg) fin_marks_reg[dir_reg] <= 1'b1;
                    if (rst_reg) rst_mark_reg <= 1'b1;
                    matched_reg <= 1'b0;
                    pass_reg    <= held_cur;
                    cur_s_reg   <= seq_reg;
                    cur_e_reg   <= send;
                    if (slen == '0) begin
                        ev_reg    <= tsgt_pkg::EV_NONE;
                        state_reg <= S_DONE;
                    end else if (!started_reg[dir_reg]) begin
                        exp_reg[dir_reg]     <= send;
                        started_reg[dir_reg] <= 1'b1;
                        ev_reg               <= tsgt_pkg::EV_FIRST;
                        state_reg            <= S_DONE;
                    end else if (ds == '0 || (tsgt_pkg::is_neg(ds) && tsgt_pkg::is_gt0(de))) begin
                        exp_reg[dir_reg] <= send;
                        ev_reg           <= tsgt_pkg::EV_ADVANCE;
                        state_reg        <= S_WALK;
                    end else if (tsgt_pkg::is_neg(ds)) begin
                        if (retx_reg != '1) retx_reg <= retx_reg + 32'd1;
                        ev_reg    <= tsgt_pkg::EV_RETRANS;
                        state_reg <= S_DONE;
                    end else begin
                        if (held_cur == '0 && gap_reg != '1) gap_reg <= gap_reg + 32'd1;
                        state_reg <= S_MERGE;
                    end
                end
                S_WALK: begin
                    if (pass_reg == '0) begin
                        // a fill moved the expected number: sweep the row again
                        if (matched_reg) begin
                            matched_reg <= 1'b0;
                            pass_reg    <= held_cur;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        pass_reg <= pass_reg - CW'(1);
                        if (!keep_c) begin
                            held_reg[dir_reg] <= held_cur - CW'(1);
                            if (tsgt_pkg::is_le0(hds) && tsgt_pkg::is_gt0(hde)) begin
                                exp_reg[dir_reg] <= hd.stop;
                                matched_reg      <= 1'b1;
                            end
                        end
                    end
                end
                S_MERGE: begin
                    if (pass_reg == '0) begin
                        if (32'(held_cur) < tsgt_pkg::MAX_PENDING) begin
                            held_reg[dir_reg] <= held_cur + CW'(1);
                            ev_reg            <= tsgt_pkg::EV_STORED;
                        end else begin
                            ev_reg <= tsgt_pkg::EV_DROPPED;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        pass_reg <= pass_reg - CW'(1);
                        if (!keep_c) begin
                            held_reg[dir_reg] <= held_cur - CW'(1);
                            if (tsgt_pkg::is_neg(hd.start - cur_s_reg)) cur_s_reg <= hd.start;
                            if (tsgt_pkg::is_gt0(hd.stop - cur_e_reg)) cur_e_reg <= hd.stop;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= ev_reg;
                        m_tdata_reg  <= {rst_mark_reg, fin_marks_reg, hs_done,
                                         gap_reg, retx_reg,
                                         tot_byte[48] ? 48'hFFFF_FFFF_FFFF : tot_byte[47:0],
                                         tot_pkt[32] ? 32'hFFFF_FFFF : tot_pkt[31:0],
                                         byte_reg[dir_reg], pkt_reg[dir_reg],
                                         held_wide, exp_reg[dir_reg]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_held0: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(held_reg[0]) <= tsgt_pkg::MAX_PENDING)
        else $error("row 0 fill count beyond capacity");

    a_held1: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(held_reg[1]) <= tsgt_pkg::MAX_PENDING)
        else $error("row 1 fill count beyond capacity");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_EVAL && !s_tready)
        else $error("accepted beat not taken into evaluation");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && (!m_tvalid || m_tready) |=> m_tvalid && state_reg == S_IDLE)
        else $error("result not presented");

endmodule

`default_nettype wire
